// ----- design/hns_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hns_pkg
// Shared types and constants for the heightmap normal stencil.
// ----------------------------------------------------------------------------
package hns_pkg;

  localparam int HEIGHT_W = 20;
  localparam int NORM_W   = 16;
  localparam int COORD_W  = 10;
  localparam int REG_W    = 11;
  localparam int INDEX_W  = 8;
  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 72;

  // input kinds carried in tuser
  localparam logic CMD_SAMPLE = 1'b0;
  localparam logic CMD_DRAIN  = 1'b1;

  // configuration register indexes
  localparam logic [INDEX_W-1:0] REG_GRID_WIDTH  = 8'd0;
  localparam logic [INDEX_W-1:0] REG_GRID_HEIGHT = 8'd1;

  localparam logic [REG_W-1:0] GRID_WIDTH_RESET  = 11'd256;
  localparam logic [REG_W-1:0] GRID_HEIGHT_RESET = 11'd256;
  localparam logic [REG_W-1:0] ROW_LIMIT         = 11'd1024;

  // squared y term of the unscaled vector: 1024^2
  localparam logic [41:0] Y_SQUARE = 42'h100000;

  // quotient bits of the scaled ratio and root bits
  localparam logic [4:0] DIV_LAST  = 5'd30;
  localparam logic [3:0] ROOT_TOP  = 4'd15;
  localparam logic [2:0] READ_LAST = 3'd4;

  typedef enum logic [3:0] {
    S_IDLE,
    S_READ,
    S_DIFF,
    S_SQA,
    S_SQB,
    S_SUM,
    S_DIV,
    S_ROOT,
    S_NEXT,
    S_HOLD
  } st_t;

  // advance a row slot 0, 1, 2, 0, ...
  function automatic logic [1:0] slot_inc(input logic [1:0] s);
    logic [1:0] r;
    case (s)
      2'd0:    r = 2'd1;
      2'd1:    r = 2'd2;
      default: r = 2'd0;
    endcase
    return r;
  endfunction

endpackage

// ----- design/heightmap_normal_stencil.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// heightmap_normal_stencil
// Streams height samples through three line buffers and returns one unit
// surface normal per grid point, normalized by an iterative divide and root.
// ----------------------------------------------------------------------------
//
//  channel   direction  payload                                   handshake
//  s_axis    in         tdata: height[19:0]; tuser: command        tvalid/tready
//  m_axis    out        tdata: nx, ny, nz, column, row; tlast      tvalid/tready
//  cfg       in         cfg_index, cfg_data (grid_width/height)    cfg_valid/ready
//
//  A request that yields a normal passes from acceptance to m_axis_tvalid
//  through 5 line buffer reads over the single read port, the DIFF, SQA,
//  SQB and SUM states of differencing, squaring and summing, then per
//  component 31 restoring divide steps, 16 root steps and one store step,
//  and the output register load. The next request is taken back in idle;
//  dropped requests and row-0 samples never leave the idle state.
//  Reset clears counters and handshakes; the line buffers are not cleared.
//  A finished normal waits in the output register while the next request
//  is taken; the unit stalls in its hold state only if that register is full.
//
module heightmap_normal_stencil #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                                clk,
  input  logic                                rst,
  // height[19:0], zero padded
  input  logic [hns_pkg::IN_DATA_W-1:0]       s_axis_tdata,
  // command[0]
  input  logic [0:0]                          s_axis_tuser,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // normal_x[15:0], normal_y[31:16], normal_z[47:32], column[57:48],
  // row[67:58], zero padded
  output logic [hns_pkg::OUT_DATA_W-1:0]      m_axis_tdata,
  output logic                                m_axis_tlast,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [hns_pkg::INDEX_W-1:0]         cfg_index,
  input  logic [hns_pkg::REG_W-1:0]           cfg_data
);
  import hns_pkg::*;

  localparam int XW     = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int WW     = XW + 1;
  localparam int DEPTH  = 3 * MAX_WIDTH;
  localparam int ADDR_W = $clog2(DEPTH);

  // configuration and its clamped views
  logic [REG_W-1:0] grid_width, grid_height;
  logic [WW-1:0]    ew;
  logic [REG_W-1:0] eh;

  // grid progress
  logic [XW-1:0]    col_count;
  logic [REG_W-1:0] row_count;
  logic             draining;
  logic [1:0]       row_rotation;

  // request latched for the stencil
  logic [XW-1:0]               x_q;
  logic [1:0]                  cslot, aslot;
  logic                        above_valid, below_valid, last_q;
  logic signed [HEIGHT_W-1:0]  below_h;
  logic [COORD_W-1:0]          z_q;

  // line buffer memory
  logic [HEIGHT_W-1:0] mem [DEPTH];
  logic                mem_we;
  logic [ADDR_W-1:0]   wr_addr, rd_addr;
  logic [HEIGHT_W-1:0] rd_data;

  // datapath
  st_t                        state, state_next;
  logic [2:0]                 rd_step;
  logic signed [HEIGHT_W-1:0] c_h, l_h, r_h, d_h;
  logic [19:0]                amag, bmag;
  logic                       aneg, bneg;
  logic [39:0]                a2, b2;
  logic [41:0]                s_sum, rem;
  logic [30:0]                quo;
  logic [4:0]                 kcnt;
  logic [15:0]                root;
  logic [3:0]                 bitn;
  logic [1:0]                 comp;
  logic [NORM_W-1:0]          res_x, res_y, res_z;

  logic                       in_acc, emit, load_out;
  logic signed [HEIGHT_W:0]   a_diff, b_diff;
  logic signed [HEIGHT_W-1:0] d_sel, u_sel;
  logic [42:0]                trial;
  logic [15:0]                cand;
  logic [31:0]                cand_sq;
  logic [15:0]                mid;
  logic [NORM_W-1:0]          comp_val;
  logic                       comp_neg;
  logic [41:0]                m2_first, m2_next;
  logic [XW-1:0]              x_left, x_right;
  logic [WW-1:0]              x_plus;

  // --------------------------------------------------------------------------
  // clamp registers to their legal range
  always_comb begin
    if (grid_width == '0) begin
      ew = WW'(1);
    end else if (32'(grid_width) > MAX_WIDTH) begin
      ew = WW'(MAX_WIDTH);
    end else begin
      ew = WW'(grid_width);
    end
    if (grid_height == '0) begin
      eh = REG_W'(1);
    end else if (grid_height > ROW_LIMIT) begin
      eh = ROW_LIMIT;
    end else begin
      eh = grid_height;
    end
  end

  assign cfg_ready = 1'b1;
  assign x_plus    = WW'(col_count) + WW'(1);

  // a sample completes the normal above it; a drain step emits the last row
  always_comb begin
    if (s_axis_tuser[0] == CMD_SAMPLE) begin
      emit = !draining && (row_count != '0);
    end else begin
      emit = draining;
    end
  end

  // --------------------------------------------------------------------------
  // control FSM
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next    = state;
    s_axis_tready = 1'b0;
    load_out      = 1'b0;
    case (state)
      S_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid && emit) begin
          state_next = S_READ;
        end
      end
      S_READ: begin
        if (rd_step == READ_LAST) begin
          state_next = S_DIFF;
        end
      end
      S_DIFF: state_next = S_SQA;
      S_SQA:  state_next = S_SQB;
      S_SQB:  state_next = S_SUM;
      S_SUM:  state_next = S_DIV;
      S_DIV: begin
        if (kcnt == DIV_LAST) begin
          state_next = S_ROOT;
        end
      end
      S_ROOT: begin
        if (bitn == '0) begin
          state_next = S_NEXT;
        end
      end
      S_NEXT: begin
        if (comp == 2'd2) begin
          state_next = S_HOLD;
        end else begin
          state_next = S_DIV;
        end
      end
      S_HOLD: begin
        // wait for room in the output register
        if (!m_axis_tvalid || m_axis_tready) begin
          load_out   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  assign in_acc = s_axis_tvalid && s_axis_tready;

  // --------------------------------------------------------------------------
  // configuration and grid counters
  always_ff @(posedge clk) begin
    if (rst) begin
      grid_width   <= GRID_WIDTH_RESET;
      grid_height  <= GRID_HEIGHT_RESET;
      col_count    <= '0;
      row_count    <= '0;
      draining     <= 1'b0;
      row_rotation <= '0;
    end else if (cfg_valid && cfg_ready &&
                 (cfg_index == REG_GRID_WIDTH || cfg_index == REG_GRID_HEIGHT)) begin
      // a write to either grid size register abandons the grid in progress
      if (cfg_index == REG_GRID_WIDTH) begin
        grid_width <= cfg_data;
      end else begin
        grid_height <= cfg_data;
      end
      col_count    <= '0;
      row_count    <= '0;
      draining     <= 1'b0;
      row_rotation <= '0;
    end else if (in_acc) begin
      if (s_axis_tuser[0] == CMD_SAMPLE && !draining) begin
        if (x_plus >= ew) begin
          col_count    <= '0;
          row_rotation <= slot_inc(row_rotation);
          row_count    <= row_count + REG_W'(1);
          if (row_count + REG_W'(1) >= eh) begin
            draining <= 1'b1;
          end
        end else begin
          col_count <= XW'(x_plus);
        end
      end else if (s_axis_tuser[0] == CMD_DRAIN && draining) begin
        if (x_plus >= ew) begin
          col_count    <= '0;
          row_count    <= '0;
          draining     <= 1'b0;
          row_rotation <= '0;
        end else begin
          col_count <= XW'(x_plus);
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // line buffer: write the incoming sample, read the stencil serially
  assign mem_we  = in_acc && (s_axis_tuser[0] == CMD_SAMPLE) && !draining;
  assign wr_addr = ADDR_W'(32'(row_rotation) * MAX_WIDTH) + ADDR_W'(col_count);

  // neighbors past the edge fall back to the centre address
  assign x_left  = (x_q != '0) ? x_q - XW'(1) : x_q;
  assign x_right = ((WW'(x_q) + WW'(1)) < ew) ? x_q + XW'(1) : x_q;

  always_comb begin
    case (rd_step)
      3'd0:    rd_addr = ADDR_W'(32'(cslot) * MAX_WIDTH) + ADDR_W'(x_q);
      3'd1:    rd_addr = ADDR_W'(32'(cslot) * MAX_WIDTH) + ADDR_W'(x_left);
      3'd2:    rd_addr = ADDR_W'(32'(cslot) * MAX_WIDTH) + ADDR_W'(x_right);
      3'd3:    rd_addr = ADDR_W'(32'(aslot) * MAX_WIDTH) + ADDR_W'(x_q);
      default: rd_addr = ADDR_W'(32'(cslot) * MAX_WIDTH) + ADDR_W'(x_q);
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_addr] <= s_axis_tdata[HEIGHT_W-1:0];
    end
    rd_data <= mem[rd_addr];
  end

  // --------------------------------------------------------------------------
  // arithmetic helpers
  assign d_sel  = above_valid ? d_h : c_h;
  assign u_sel  = below_valid ? below_h : c_h;
  assign a_diff = (HEIGHT_W+1)'(l_h) - (HEIGHT_W+1)'(r_h);
  assign b_diff = (HEIGHT_W+1)'(d_sel) - (HEIGHT_W+1)'(u_sel);

  // first shift-free step covers the y case where m2 equals the sum
  assign trial   = (kcnt == '0) ? {1'b0, rem} : {rem, 1'b0};
  assign cand    = root | (16'd1 << bitn);
  assign cand_sq = 32'(cand) * 32'(cand);
  // largest odd t not above the root gives the rounded component (t + 1) / 2
  assign mid     = 16'((17'(root) + 17'd1) >> 1);

  always_comb begin
    case (comp)
      2'd0:    comp_neg = aneg;
      2'd2:    comp_neg = bneg;
      default: comp_neg = 1'b0;
    endcase
    comp_val = comp_neg ? NORM_W'(16'd0 - mid) : mid;
  end

  assign m2_first = 42'(a2);
  assign m2_next  = (comp == 2'd0) ? Y_SQUARE : 42'(b2);

  // --------------------------------------------------------------------------
  // datapath registers
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        rd_step <= '0;
        x_q     <= col_count;
        below_h <= s_axis_tdata[HEIGHT_W-1:0];
        // centre row is one slot behind the incoming one, the row above it two
        cslot   <= slot_inc(slot_inc(row_rotation));
        aslot   <= slot_inc(row_rotation);
        if (s_axis_tuser[0] == CMD_SAMPLE) begin
          above_valid <= row_count >= REG_W'(2);
          below_valid <= 1'b1;
          z_q         <= COORD_W'(row_count - REG_W'(1));
          last_q      <= 1'b0;
        end else begin
          above_valid <= eh >= REG_W'(2);
          below_valid <= 1'b0;
          z_q         <= COORD_W'(eh - REG_W'(1));
          last_q      <= x_plus >= ew;
        end
      end
      S_READ: begin
        rd_step <= rd_step + 3'd1;
        case (rd_step)
          3'd1:    c_h <= rd_data;
          3'd2:    l_h <= rd_data;
          3'd3:    r_h <= rd_data;
          3'd4:    d_h <= rd_data;
          default: ;
        endcase
      end
      S_DIFF: begin
        aneg <= a_diff[HEIGHT_W];
        bneg <= b_diff[HEIGHT_W];
        amag <= a_diff[HEIGHT_W] ? 20'(-a_diff) : a_diff[19:0];
        bmag <= b_diff[HEIGHT_W] ? 20'(-b_diff) : b_diff[19:0];
      end
      S_SQA: a2 <= 40'(amag) * 40'(amag);
      S_SQB: b2 <= 40'(bmag) * 40'(bmag);
      S_SUM: begin
        s_sum <= 42'(a2) + 42'(b2) + Y_SQUARE;
        comp  <= '0;
        rem   <= m2_first;
        quo   <= '0;
        kcnt  <= '0;
      end
      S_DIV: begin
        // restoring divide: floor(m2 * 2^30 / s), one bit per cycle
        if (trial >= {1'b0, s_sum}) begin
          rem <= 42'(trial - {1'b0, s_sum});
          quo <= {quo[29:0], 1'b1};
        end else begin
          rem <= trial[41:0];
          quo <= {quo[29:0], 1'b0};
        end
        kcnt <= kcnt + 5'd1;
        root <= '0;
        bitn <= ROOT_TOP;
      end
      S_ROOT: begin
        if (cand_sq <= {1'b0, quo}) begin
          root <= cand;
        end
        bitn <= bitn - 4'd1;
      end
      S_NEXT: begin
        case (comp)
          2'd0:    res_x <= comp_val;
          2'd1:    res_y <= comp_val;
          default: res_z <= comp_val;
        endcase
        comp <= comp + 2'd1;
        rem  <= m2_next;
        quo  <= '0;
        kcnt <= '0;
      end
      default: ;
    endcase
  end

  // --------------------------------------------------------------------------
  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (load_out) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      m_axis_tdata <= {4'd0, z_q, COORD_W'(x_q), res_z, res_y, res_x};
      m_axis_tlast <= last_q;
    end
  end

  // --------------------------------------------------------------------------
  // assertions
  a_col_in_row: assert property (@(posedge clk) disable iff (rst)
    WW'(col_count) < ew)
    else $error("column counter ran past the row width");

  a_drain_row: assert property (@(posedge clk) disable iff (rst)
    draining |-> row_count == eh)
    else $error("draining before all rows arrived");

  a_ny_positive: assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> !m_axis_tdata[31] && m_axis_tdata[31:16] != '0)
    else $error("normal y component not positive");

endmodule

// ----- tb/tb_heightmap_normal_stencil.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_heightmap_normal_stencil
// Self-checking bench for the heightmap normal stencil: drives grids of height
// samples and drain steps over the input stream, reprograms the grid size
// between grids, and checks each normal against an in-bench model or typed value.
// ----------------------------------------------------------------------------
module tb_heightmap_normal_stencil;
  import hns_pkg::*;

  localparam int ROW_SLOTS = 1024;
  localparam int TARGET_ITEMS = 1900;
  localparam int SETTLE_CYCLES = 200;
  localparam logic [INDEX_W-1:0] REG_SPARE = 8'd2;
  localparam logic [NORM_W-1:0] UNIT_Q14 = 16'd16384;

  typedef struct packed {
    logic [NORM_W-1:0]  nx;
    logic [NORM_W-1:0]  ny;
    logic [NORM_W-1:0]  nz;
    logic [COORD_W-1:0] column;
    logic [COORD_W-1:0] row;
    logic               last;
  } normal_t;

  typedef struct {
    logic                 kind;
    logic [HEIGHT_W-1:0]  height;
    bit                   known;   // use the typed-in normal below
    normal_t              want;
  } request_t;

  typedef struct {
    bit                   is_reg;
    logic [INDEX_W-1:0]   index;
    logic [REG_W-1:0]     value;
    request_t             req;
  } script_row_t;

  logic clk;
  logic rst;
  logic [IN_DATA_W-1:0]  s_axis_tdata;
  logic [0:0]            s_axis_tuser;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic                  m_axis_tlast;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [INDEX_W-1:0]    cfg_index;
  logic [REG_W-1:0]      cfg_data;

  heightmap_normal_stencil u_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  // --------------------------------------------------------------------------
  // Surface model: row buffers, raster counters and grid size
  // --------------------------------------------------------------------------
  int          height_rows [3][ROW_SLOTS];
  int unsigned grid_w_reg;
  int unsigned grid_h_reg;
  int unsigned col_pos;
  int unsigned row_pos;
  int unsigned fill_slot;
  bit          in_drain;

  request_t pending_requests[$];
  normal_t  expected_normals[$];
  int       failures;
  int       accepted_items;
  bit       calm;   // no idling on either side while set

  function automatic int unsigned active_width();
    int unsigned w;
    w = grid_w_reg;
    if (w == 0) w = 1;
    if (w > ROW_SLOTS) w = ROW_SLOTS;
    return w;
  endfunction

  function automatic int unsigned active_height();
    int unsigned h;
    h = grid_h_reg;
    if (h == 0) h = 1;
    if (h > ROW_LIMIT) h = ROW_LIMIT;
    return h;
  endfunction

  // Round 16384 * |v| / sqrt(s) to nearest, ties away from zero: find the
  // largest q with (2q-1)^2 * s <= 4 * 2^28 * v^2.
  function automatic logic [NORM_W-1:0] unit_part(longint v, longint unsigned s);
    longint unsigned mag;
    longint unsigned odd;
    logic [127:0]    bound;
    logic [127:0]    prod;
    int unsigned     lo;
    int unsigned     hi;
    int unsigned     mid;
    mag = (v < 0) ? -v : v;
    bound = {64'd0, mag * mag} << 30;
    lo = 0;
    hi = 16384;
    while (lo < hi) begin
      mid = (lo + hi + 1) / 2;
      odd = 2 * longint'(mid) - 1;
      prod = 128'(odd * odd) * 128'(s);
      if (prod <= bound) lo = mid;
      else hi = mid - 1;
    end
    return (v < 0) ? NORM_W'(-lo) : NORM_W'(lo);
  endfunction

  // Normal of column x in the row held in slot mid_slot.
  function automatic normal_t surface_normal(int unsigned mid_slot, int unsigned up_slot,
                                             bit up_ok, bit down_ok, int below,
                                             int unsigned x, int unsigned z, bit is_last);
    int      c;
    int      l;
    int      r;
    int      d;
    int      u;
    longint  a;
    longint  b;
    longint unsigned s;
    normal_t n;
    c = height_rows[mid_slot][x];
    l = (x > 0) ? height_rows[mid_slot][x - 1] : c;
    r = (x + 1 < active_width()) ? height_rows[mid_slot][x + 1] : c;
    d = up_ok ? height_rows[up_slot][x] : c;
    u = down_ok ? below : c;
    a = longint'(l) - longint'(r);
    b = longint'(d) - longint'(u);
    s = a * a + (longint'(1) << 20) + b * b;
    n.nx = unit_part(a, s);
    n.ny = unit_part(1024, s);
    n.nz = unit_part(b, s);
    n.column = COORD_W'(x);
    n.row = COORD_W'(z);
    n.last = is_last;
    return n;
  endfunction

  function automatic void restart_grid();
    col_pos = 0;
    row_pos = 0;
    in_drain = 0;
    fill_slot = 0;
  endfunction

  // Advance the model by one accepted request; queue the normal it yields.
  function automatic void take_request(request_t q);
    int          h;
    int unsigned x;
    bit          made;
    normal_t     n;
    h = int'($signed(q.height));
    x = col_pos;
    made = 0;
    if (q.kind == CMD_SAMPLE) begin
      if (in_drain) return;   // drop: wrong phase
      height_rows[fill_slot][x] = h;
      if (row_pos >= 1) begin
        n = surface_normal((fill_slot + 2) % 3, (fill_slot + 1) % 3, row_pos >= 2, 1, h,
                           x, row_pos - 1, 0);
        made = 1;
      end
      col_pos = x + 1;
      if (col_pos >= active_width()) begin
        col_pos = 0;
        fill_slot = (fill_slot + 1) % 3;
        row_pos++;
        if (row_pos >= active_height()) in_drain = 1;
      end
    end else begin
      if (!in_drain) return;  // drop: nothing to drain yet
      n = surface_normal((fill_slot + 2) % 3, (fill_slot + 1) % 3, active_height() >= 2, 0, 0,
                         x, active_height() - 1, x + 1 >= active_width());
      made = 1;
      col_pos = x + 1;
      if (n.last) restart_grid();
    end
    accepted_items++;
    if (made) expected_normals = {expected_normals, (q.known ? q.want : n)};
  endfunction

  // --------------------------------------------------------------------------
  // Clock, reset, timeout
  // --------------------------------------------------------------------------
  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  initial begin
    #5ms;
    $display("TB_ERROR");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Request driver: hold a presented request until taken, idle at random
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) take_request(pending_requests.pop_front());
      if (s_axis_tvalid && !s_axis_tready) begin
        // hold the current request
      end else if (pending_requests.size() > 0 && (calm || $urandom_range(99) >= 23)) begin
        s_axis_tvalid <= 1;
        s_axis_tuser <= pending_requests[0].kind;
        s_axis_tdata <= {{(IN_DATA_W - HEIGHT_W){1'b0}}, pending_requests[0].height};
      end else begin
        s_axis_tvalid <= 0;
      end
    end
  end

  // Result side: stall at random, check each normal against the oldest one due
  always @(posedge clk) begin
    m_axis_tready <= !rst && (calm || $urandom_range(99) >= 23);
  end

  always @(posedge clk) begin
    normal_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (expected_normals.size() == 0) begin
        $error("unexpected normal: tdata=%h tlast=%b", m_axis_tdata, m_axis_tlast);
        failures++;
      end else begin
        want = expected_normals.pop_front();
        if (m_axis_tdata[15:0] !== want.nx) begin
          $error("normal_x: expected %h actual %h", want.nx, m_axis_tdata[15:0]);
          failures++;
        end
        if (m_axis_tdata[31:16] !== want.ny) begin
          $error("normal_y: expected %h actual %h", want.ny, m_axis_tdata[31:16]);
          failures++;
        end
        if (m_axis_tdata[47:32] !== want.nz) begin
          $error("normal_z: expected %h actual %h", want.nz, m_axis_tdata[47:32]);
          failures++;
        end
        if (m_axis_tdata[57:48] !== want.column) begin
          $error("column: expected %0d actual %0d", want.column, m_axis_tdata[57:48]);
          failures++;
        end
        if (m_axis_tdata[67:58] !== want.row) begin
          $error("row: expected %0d actual %0d", want.row, m_axis_tdata[67:58]);
          failures++;
        end
        if (m_axis_tlast !== want.last) begin
          $error("last: expected %b actual %b", want.last, m_axis_tlast);
          failures++;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  // Wait until every request is taken and every normal returned, then let
  // any dropped or row-0 request finish inside the block.
  task automatic settle();
    int guard;
    guard = 0;
    while ((pending_requests.size() > 0 || expected_normals.size() > 0) && guard < 400000) begin
      @(posedge clk);
      guard++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [INDEX_W-1:0] idx, logic [REG_W-1:0] val);
    settle();
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 0;
    if (idx == REG_GRID_WIDTH) begin
      grid_w_reg = val;
      restart_grid();
    end else if (idx == REG_GRID_HEIGHT) begin
      grid_h_reg = val;
      restart_grid();
    end
  endtask

  task automatic queue_item(logic kind, logic [HEIGHT_W-1:0] h);
    request_t q;
    q.kind = kind;
    q.height = h;
    q.known = 0;
    q.want = '0;
    pending_requests = {pending_requests, q};
  endtask

  function automatic logic [HEIGHT_W-1:0] random_height();
    case ($urandom_range(3))
      0:       return HEIGHT_W'($urandom);
      1:       return HEIGHT_W'($urandom_range(4095) - 2048);
      2:       return HEIGHT_W'($urandom_range(255));
      default: return $urandom_range(1) ? 20'h80000 : 20'h7FFFF;
    endcase
  endfunction

  script_row_t script[$];

  function automatic void add_reg(logic [INDEX_W-1:0] idx, logic [REG_W-1:0] val);
    script_row_t s;
    s.is_reg = 1;
    s.index = idx;
    s.value = val;
    s.req = '{CMD_SAMPLE, '0, 0, '0};
    script = {script, s};
  endfunction

  // known: the normal is flat and its position is plain from the grid shape
  function automatic void add_item(logic kind, logic [HEIGHT_W-1:0] h, bit known = 0,
                                   int unsigned x = 0, int unsigned z = 0, bit is_last = 0);
    script_row_t s;
    s.is_reg = 0;
    s.index = '0;
    s.value = '0;
    s.req.kind = kind;
    s.req.height = h;
    s.req.known = known;
    s.req.want = '{0, UNIT_Q14, 0, COORD_W'(x), COORD_W'(z), is_last};
    script = {script, s};
  endfunction

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    int unsigned w;
    int unsigned h;
    int          grid_no;
    failures = 0;
    accepted_items = 0;
    calm = 0;
    grid_w_reg = GRID_WIDTH_RESET;
    grid_h_reg = GRID_HEIGHT_RESET;
    restart_grid();
    s_axis_tdata = '0;
    s_axis_tuser = CMD_SAMPLE;
    s_axis_tvalid = 0;
    m_axis_tready = 0;
    cfg_valid = 0;
    cfg_index = REG_GRID_WIDTH;
    cfg_data = '0;
    rst = 1;
    repeat (9) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // 2 x 2 flat grid, with a drain too early and a sample too late
    add_reg(REG_GRID_WIDTH, 11'd2);
    add_reg(REG_GRID_HEIGHT, 11'd2);
    add_item(CMD_DRAIN, 20'd0);
    add_item(CMD_SAMPLE, 20'd0);
    add_item(CMD_SAMPLE, 20'd0);
    add_item(CMD_SAMPLE, 20'd0, 1, 0, 0, 0);
    add_item(CMD_SAMPLE, 20'd0, 1, 1, 0, 0);
    add_item(CMD_SAMPLE, 20'd5);
    add_item(CMD_DRAIN, 20'd0, 1, 0, 1, 0);
    add_item(CMD_DRAIN, 20'd0, 1, 1, 1, 1);
    // single-row grid at the height extremes
    add_reg(REG_GRID_WIDTH, 11'd3);
    add_reg(REG_GRID_HEIGHT, 11'd1);
    add_item(CMD_SAMPLE, 20'h80000);
    add_item(CMD_SAMPLE, 20'h7FFFF);
    add_item(CMD_SAMPLE, 20'h80000);
    add_item(CMD_DRAIN, 20'd0);
    add_item(CMD_DRAIN, 20'd0);
    add_item(CMD_DRAIN, 20'd0);
    // zero size acts as a 1 x 1 grid; an unknown index changes nothing
    add_reg(REG_GRID_WIDTH, 11'd0);
    add_reg(REG_GRID_HEIGHT, 11'd0);
    add_reg(REG_SPARE, 11'h7FF);
    add_item(CMD_SAMPLE, 20'h7FFFF);
    add_item(CMD_DRAIN, 20'd0, 1, 0, 0, 1);

    foreach (script[i]) begin
      if (script[i].is_reg) write_reg(script[i].index, script[i].value);
      else pending_requests = {pending_requests, script[i].req};
    end

    // Widest row (oversize width clamps), then abandon after a few normals
    write_reg(REG_GRID_WIDTH, 11'h7FF);
    write_reg(REG_GRID_HEIGHT, 11'd2);
    for (int i = 0; i < ROW_SLOTS + 6; i++) queue_item(CMD_SAMPLE, random_height());
    settle();
    // Tallest grid (oversize height clamps), one column, abandoned early
    write_reg(REG_GRID_HEIGHT, 11'h7FF);
    write_reg(REG_GRID_WIDTH, 11'd1);
    for (int i = 0; i < 12; i++) queue_item(CMD_SAMPLE, random_height());
    write_reg(REG_GRID_HEIGHT, 11'd1024);
    write_reg(REG_GRID_WIDTH, 11'd1024);

    // Random grids: mostly complete ones, some noise and some cut short
    grid_no = 0;
    while (accepted_items < TARGET_ITEMS) begin
      w = ($urandom_range(9) == 0) ? $urandom_range(40, 9) : $urandom_range(8, 1);
      h = $urandom_range(6, 1);
      calm = (grid_no >= 15 && grid_no < 30);
      if ($urandom_range(1)) begin
        write_reg(REG_GRID_WIDTH, REG_W'(w));
        write_reg(REG_GRID_HEIGHT, REG_W'(h));
      end else begin
        write_reg(REG_GRID_HEIGHT, REG_W'(h));
        write_reg(REG_GRID_WIDTH, REG_W'(w));
      end
      for (int i = 0; i < w * h; i++) begin
        if ($urandom_range(19) == 0) queue_item(CMD_DRAIN, random_height());
        queue_item(CMD_SAMPLE, random_height());
      end
      if ($urandom_range(7) != 0) begin
        for (int i = 0; i < w; i++) begin
          if ($urandom_range(19) == 0) queue_item(CMD_SAMPLE, random_height());
          queue_item(CMD_DRAIN, random_height());
        end
      end
      grid_no++;
      settle();
    end
    calm = 0;

    settle();
    if (failures == 0 && expected_normals.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
